[hdl/bsma_pkg.sv]
// ----------------------------------------------------------------------------
// bsma_pkg
// Types, widths and the control store for the baryon singlet accumulator.
// ----------------------------------------------------------------------------
package bsma_pkg;

  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = COMP_BITS - 1;
  localparam int WORD_BITS = 2 * COMP_BITS;
  localparam int ACC_BITS  = 48;
  localparam int DQ_BITS   = 2 * FRAC_BITS + 4;
  localparam int OPA_BITS  = 2 * FRAC_BITS + 8;
  localparam int PROD_BITS = OPA_BITS + COMP_BITS;
  localparam int MAC_BITS  = PROD_BITS + 2;
  localparam int TERM_BITS = MAC_BITS - FRAC_BITS;
  localparam int SUM_BITS  = ACC_BITS + 1;
  localparam int PROG_LEN  = 13;
  localparam int STEP_BITS = $clog2(PROG_LEN);

  typedef struct packed {
    logic [WORD_BITS-1:0] q1_red;
    logic [WORD_BITS-1:0] q1_green;
    logic [WORD_BITS-1:0] q1_blue;
    logic [WORD_BITS-1:0] q2_red;
    logic [WORD_BITS-1:0] q2_green;
    logic [WORD_BITS-1:0] q2_blue;
    logic [WORD_BITS-1:0] q3_red;
    logic [WORD_BITS-1:0] q3_green;
    logic [WORD_BITS-1:0] q3_blue;
    logic [WORD_BITS-1:0] phase;
    logic                 last_site;
  } item_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] sum_real;
    logic signed [ACC_BITS-1:0] sum_imag;
    logic                       saturated;
  } result_t;

  typedef enum logic [2:0] {
    A_Q1_RED, A_Q1_GREEN, A_Q1_BLUE, A_DQ0, A_DQ1, A_DQ2, A_SINGLET
  } a_sel_t;

  typedef enum logic [2:0] {
    B_Q2_RED, B_Q2_GREEN, B_Q2_BLUE, B_Q3_RED, B_Q3_GREEN, B_Q3_BLUE, B_PHASE
  } b_sel_t;

  typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_t;
  typedef enum logic [1:0] {ST_NONE, ST_DQ0, ST_DQ1, ST_DQ2} store_t;
  typedef enum logic {SEQ_NEXT, SEQ_END} seq_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    mac_op_t mac_op;
    store_t  store;
    seq_t    seq;
  } ctrl_t;

  // Product registers hold products of the prior step's operands; mac_op acts on them.
  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_t c;
    unique case (step)
      4'd0:    c = '{A_Q1_GREEN, B_Q2_BLUE,  MAC_HOLD, ST_NONE, SEQ_NEXT};
      4'd1:    c = '{A_Q1_BLUE,  B_Q2_GREEN, MAC_LOAD, ST_NONE, SEQ_NEXT};
      4'd2:    c = '{A_Q1_BLUE,  B_Q2_RED,   MAC_SUB,  ST_NONE, SEQ_NEXT};
      4'd3:    c = '{A_Q1_RED,   B_Q2_BLUE,  MAC_LOAD, ST_DQ0,  SEQ_NEXT};
      4'd4:    c = '{A_Q1_RED,   B_Q2_GREEN, MAC_SUB,  ST_NONE, SEQ_NEXT};
      4'd5:    c = '{A_Q1_GREEN, B_Q2_RED,   MAC_LOAD, ST_DQ1,  SEQ_NEXT};
      4'd6:    c = '{A_DQ0,      B_Q3_RED,   MAC_SUB,  ST_NONE, SEQ_NEXT};
      4'd7:    c = '{A_DQ1,      B_Q3_GREEN, MAC_LOAD, ST_DQ2,  SEQ_NEXT};
      4'd8:    c = '{A_DQ2,      B_Q3_BLUE,  MAC_ADD,  ST_NONE, SEQ_NEXT};
      4'd9:    c = '{A_Q1_RED,   B_Q2_RED,   MAC_ADD,  ST_NONE, SEQ_NEXT};
      4'd10:   c = '{A_SINGLET,  B_PHASE,    MAC_HOLD, ST_NONE, SEQ_NEXT};
      4'd11:   c = '{A_Q1_RED,   B_Q2_RED,   MAC_LOAD, ST_NONE, SEQ_NEXT};
      default: c = '{A_Q1_RED,   B_Q2_RED,   MAC_HOLD, ST_NONE, SEQ_END};
    endcase
    return c;
  endfunction

endpackage

[hdl/baryon_singlet_momentum_accumulate.sv]
// ----------------------------------------------------------------------------
// baryon_singlet_momentum_accumulate
// Per-site baryon colour-singlet contraction, phase projection and sum.
// ----------------------------------------------------------------------------
// Each site word is captured in a register on acceptance; the block is not
// ready for the next one until it has run all 13 steps of a microcode program
// that drives a single shared complex multiplier (six steps of diquark, three
// of singlet, one of phase, two steps of product latency and a final
// saturating accumulate). On a last-site word the sum goes to a result
// register; the next sum may start while it waits, and the program holds on
// its final step only if a second result is due before the first is taken.
module baryon_singlet_momentum_accumulate (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bsma_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output bsma_pkg::result_t result
);
  import bsma_pkg::*;

  item_t                        site;
  logic                         busy;
  logic [STEP_BITS-1:0]         step;
  ctrl_t                        uc;
  logic                         accept;
  logic                         at_end;
  logic                         stall;
  logic                         advance;
  logic                         emit;

  logic signed [OPA_BITS-1:0]   a_re, a_im;
  logic signed [COMP_BITS-1:0]  b_re, b_im;
  logic signed [PROD_BITS-1:0]  p_rr, p_ii, p_ri, p_ir;
  logic signed [MAC_BITS-1:0]   prod_re, prod_im;
  logic signed [MAC_BITS-1:0]   mac_re, mac_im, mac_re_next, mac_im_next;
  logic signed [DQ_BITS-1:0]    dq0_re, dq0_im, dq1_re, dq1_im, dq2_re, dq2_im;

  logic signed [ACC_BITS-1:0]   acc_real, acc_imag;
  logic                         clip_seen;
  logic signed [TERM_BITS-1:0]  term_re, term_im;
  logic signed [SUM_BITS-1:0]   sum_re, sum_im;
  logic signed [ACC_BITS-1:0]   acc_real_next, acc_imag_next;
  logic                         clip_re, clip_im;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  assign uc         = ucode(step);
  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;
  assign at_end     = busy && (uc.seq == SEQ_END);
  assign stall      = at_end && site.last_site && result_valid && !result_ready;
  assign advance    = busy && !stall;
  assign emit       = at_end && advance && site.last_site;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= '0;
    end else if (advance) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      site <= item;
    end
  end

  always_comb begin
    unique case (uc.a_sel)
      A_Q1_RED: begin
        a_re = OPA_BITS'($signed(site.q1_red[WORD_BITS-1:COMP_BITS]));
        a_im = OPA_BITS'($signed(site.q1_red[COMP_BITS-1:0]));
      end
      A_Q1_GREEN: begin
        a_re = OPA_BITS'($signed(site.q1_green[WORD_BITS-1:COMP_BITS]));
        a_im = OPA_BITS'($signed(site.q1_green[COMP_BITS-1:0]));
      end
      A_Q1_BLUE: begin
        a_re = OPA_BITS'($signed(site.q1_blue[WORD_BITS-1:COMP_BITS]));
        a_im = OPA_BITS'($signed(site.q1_blue[COMP_BITS-1:0]));
      end
      A_DQ0: begin
        a_re = OPA_BITS'(dq0_re);
        a_im = OPA_BITS'(dq0_im);
      end
      A_DQ1: begin
        a_re = OPA_BITS'(dq1_re);
        a_im = OPA_BITS'(dq1_im);
      end
      A_DQ2: begin
        a_re = OPA_BITS'(dq2_re);
        a_im = OPA_BITS'(dq2_im);
      end
      A_SINGLET: begin
        a_re = $signed(mac_re[FRAC_BITS +: OPA_BITS]);
        a_im = $signed(mac_im[FRAC_BITS +: OPA_BITS]);
      end
      default: begin
        a_re = '0;
        a_im = '0;
      end
    endcase
  end

  always_comb begin
    unique case (uc.b_sel)
      B_Q2_RED: begin
        b_re = $signed(site.q2_red[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.q2_red[COMP_BITS-1:0]);
      end
      B_Q2_GREEN: begin
        b_re = $signed(site.q2_green[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.q2_green[COMP_BITS-1:0]);
      end
      B_Q2_BLUE: begin
        b_re = $signed(site.q2_blue[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.q2_blue[COMP_BITS-1:0]);
      end
      B_Q3_RED: begin
        b_re = $signed(site.q3_red[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.q3_red[COMP_BITS-1:0]);
      end
      B_Q3_GREEN: begin
        b_re = $signed(site.q3_green[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.q3_green[COMP_BITS-1:0]);
      end
      B_Q3_BLUE: begin
        b_re = $signed(site.q3_blue[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.q3_blue[COMP_BITS-1:0]);
      end
      B_PHASE: begin
        b_re = $signed(site.phase[WORD_BITS-1:COMP_BITS]);
        b_im = $signed(site.phase[COMP_BITS-1:0]);
      end
      default: begin
        b_re = '0;
        b_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
    end
  end

  assign prod_re = MAC_BITS'(p_rr) - MAC_BITS'(p_ii);
  assign prod_im = MAC_BITS'(p_ri) + MAC_BITS'(p_ir);

  always_comb begin
    unique case (uc.mac_op)
      MAC_HOLD: begin
        mac_re_next = mac_re;
        mac_im_next = mac_im;
      end
      MAC_LOAD: begin
        mac_re_next = prod_re;
        mac_im_next = prod_im;
      end
      MAC_ADD: begin
        mac_re_next = mac_re + prod_re;
        mac_im_next = mac_im + prod_im;
      end
      MAC_SUB: begin
        mac_re_next = mac_re - prod_re;
        mac_im_next = mac_im - prod_im;
      end
      default: begin
        mac_re_next = mac_re;
        mac_im_next = mac_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mac_re <= mac_re_next;
      mac_im <= mac_im_next;
      unique case (uc.store)
        ST_NONE: begin
        end
        ST_DQ0: begin
          dq0_re <= mac_re[DQ_BITS-1:0];
          dq0_im <= mac_im[DQ_BITS-1:0];
        end
        ST_DQ1: begin
          dq1_re <= mac_re[DQ_BITS-1:0];
          dq1_im <= mac_im[DQ_BITS-1:0];
        end
        ST_DQ2: begin
          dq2_re <= mac_re[DQ_BITS-1:0];
          dq2_im <= mac_im[DQ_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign term_re = $signed(mac_re[MAC_BITS-1:FRAC_BITS]);
  assign term_im = $signed(mac_im[MAC_BITS-1:FRAC_BITS]);
  assign sum_re  = SUM_BITS'(acc_real) + SUM_BITS'(term_re);
  assign sum_im  = SUM_BITS'(acc_imag) + SUM_BITS'(term_im);
  assign clip_re = sum_re[SUM_BITS-1] != sum_re[SUM_BITS-2];
  assign clip_im = sum_im[SUM_BITS-1] != sum_im[SUM_BITS-2];

  always_comb begin
    if (clip_re) begin
      acc_real_next = sum_re[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_real_next = sum_re[ACC_BITS-1:0];
    end
    if (clip_im) begin
      acc_imag_next = sum_im[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_imag_next = sum_im[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_real  <= '0;
      acc_imag  <= '0;
      clip_seen <= 1'b0;
    end else if (emit) begin
      acc_real  <= '0;
      acc_imag  <= '0;
      clip_seen <= 1'b0;
    end else if (at_end && advance) begin
      acc_real  <= acc_real_next;
      acc_imag  <= acc_imag_next;
      clip_seen <= clip_seen || clip_re || clip_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.sum_real  <= acc_real_next;
      result.sum_imag  <= acc_imag_next;
      result.saturated <= clip_seen || clip_re || clip_im;
    end
  end

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    (advance && !at_end) |=> (busy && step == $past(step) + 1'b1))
    else $error("step counter did not advance");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step < STEP_BITS'(PROG_LEN)))
    else $error("step counter beyond program");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(at_end && site.last_site))
    else $error("result raised outside final step of a last site");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (acc_real == '0 && acc_imag == '0 && !clip_seen))
    else $error("accumulator not cleared after result");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && step == '0))
    else $error("program did not start at step zero");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for baryon_singlet_momentum_accumulate. Site words go
// in over a valid/ready channel and a bit-exact predictor folds each accepted
// word into its own complex accumulator, queueing the expected sum on every
// last site. Sums coming out are compared field by field in order. Tests
// cover operand extremes, long sums of large singlets of both signs, a long
// output stall that backs up the input, and random sums of varied length.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsma_pkg::*;

  localparam longint ACC_MAX     = (longint'(1) << (ACC_BITS - 1)) - 1;
  localparam longint ACC_MIN     = -ACC_MAX - 1;
  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     MAX_PRINTS  = 100;

  localparam logic [WORD_BITS-1:0] W_ZERO = 32'h0000_0000;
  localparam logic [WORD_BITS-1:0] W_ONE  = 32'h7FFF_0000;
  localparam logic [WORD_BITS-1:0] W_NEG  = 32'h8000_0000;
  localparam logic [WORD_BITS-1:0] W_J    = 32'h0000_7FFF;
  localparam logic [WORD_BITS-1:0] W_MAXC = 32'h7FFF_7FFF;
  localparam logic [WORD_BITS-1:0] W_MINC = 32'h8000_8000;
  localparam logic [WORD_BITS-1:0] W_CONJ = 32'h7FFF_8000;
  localparam logic [WORD_BITS-1:0] W_TINY = 32'hFFFF_FFFF;

  logic    clk;
  logic    rst;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  longint  acc_real_m;
  longint  acc_imag_m;
  bit      clip_seen_m;
  result_t pending_sums[$];
  result_t want;

  int      errors = 0;
  int      sites_sent = 0;
  int      sums_checked = 0;
  int      cycles = 0;
  bit      calm = 1'b0;
  int      rx_hold = 0;

  baryon_singlet_momentum_accumulate u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR: %s", msg);
    errors++;
  endtask

  function automatic longint cmul_re(longint ar, longint ai, longint br, longint bi);
    return ar * br - ai * bi;
  endfunction

  function automatic longint cmul_im(longint ar, longint ai, longint br, longint bi);
    return ar * bi + ai * br;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // fold one site into the running sum; queue the sum on a last site
  task automatic fold_site(input item_t w);
    logic [WORD_BITS-1:0] words[10];
    longint qr[10];
    longint qi[10];
    longint dr[3];
    longint di[3];
    longint s_re, s_im, t_re, t_im, nr, ni;
    int i, j;
    result_t r;
    words[0] = w.q1_red;  words[1] = w.q1_green; words[2] = w.q1_blue;
    words[3] = w.q2_red;  words[4] = w.q2_green; words[5] = w.q2_blue;
    words[6] = w.q3_red;  words[7] = w.q3_green; words[8] = w.q3_blue;
    words[9] = w.phase;
    for (int k = 0; k < 10; k++) begin
      qr[k] = $signed(words[k][WORD_BITS-1:COMP_BITS]);
      qi[k] = $signed(words[k][COMP_BITS-1:0]);
    end
    for (int c = 0; c < 3; c++) begin
      i = (c + 1) % 3;
      j = (c + 2) % 3;
      dr[c] = cmul_re(qr[i], qi[i], qr[3+j], qi[3+j]) - cmul_re(qr[j], qi[j], qr[3+i], qi[3+i]);
      di[c] = cmul_im(qr[i], qi[i], qr[3+j], qi[3+j]) - cmul_im(qr[j], qi[j], qr[3+i], qi[3+i]);
    end
    s_re = 0;
    s_im = 0;
    for (int c = 0; c < 3; c++) begin
      s_re += cmul_re(dr[c], di[c], qr[6+c], qi[6+c]);
      s_im += cmul_im(dr[c], di[c], qr[6+c], qi[6+c]);
    end
    s_re = s_re >>> FRAC_BITS;
    s_im = s_im >>> FRAC_BITS;
    t_re = cmul_re(s_re, s_im, qr[9], qi[9]) >>> FRAC_BITS;
    t_im = cmul_im(s_re, s_im, qr[9], qi[9]) >>> FRAC_BITS;
    nr = acc_real_m + t_re;
    ni = acc_imag_m + t_im;
    acc_real_m = clamp_acc(nr);
    acc_imag_m = clamp_acc(ni);
    if (acc_real_m != nr || acc_imag_m != ni) clip_seen_m = 1'b1;
    if (w.last_site) begin
      r.sum_real  = acc_real_m[ACC_BITS-1:0];
      r.sum_imag  = acc_imag_m[ACC_BITS-1:0];
      r.saturated = clip_seen_m;
      pending_sums.push_back(r);
      acc_real_m  = 0;
      acc_imag_m  = 0;
      clip_seen_m = 1'b0;
    end
  endtask

  // enter and leave at a falling edge; valid stays high for a following word
  task automatic send_site(input item_t w);
    while (!calm && $urandom_range(99) < 13) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = w;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    fold_site(w);
    sites_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_valid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
  endtask

  function automatic item_t make_site(
    input logic [WORD_BITS-1:0] r1, g1, b1, r2, g2, b2, r3, g3, b3, ph,
    input logic last);
    item_t w;
    w.q1_red = r1; w.q1_green = g1; w.q1_blue = b1;
    w.q2_red = r2; w.q2_green = g2; w.q2_blue = b2;
    w.q3_red = r3; w.q3_green = g3; w.q3_blue = b3;
    w.phase = ph;
    w.last_site = last;
    return w;
  endfunction

  // rows of a determinant -4 sign matrix scaled by (1+i): singlet near 8-8i
  function automatic item_t det_site(input logic [WORD_BITS-1:0] ph, input logic last);
    return make_site(W_MINC, W_MINC, W_MINC, W_MINC, W_MAXC, W_MINC,
                     W_MINC, W_MINC, W_MAXC, ph, last);
  endfunction

  function automatic logic [COMP_BITS-1:0] edge_half();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    if ($urandom_range(9) < 2) return {edge_half(), edge_half()};
    return $urandom();
  endfunction

  function automatic item_t random_site(input logic last);
    return make_site(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), last);
  endfunction

  task automatic test_directed();
    send_site(make_site(W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
                        W_ZERO, W_ZERO, W_ZERO, W_ZERO, 1'b1));
    send_site(make_site(W_TINY, W_TINY, W_TINY, W_TINY, W_TINY, W_TINY,
                        W_TINY, W_TINY, W_TINY, W_TINY, 1'b1));
    send_site(make_site(W_MINC, W_MINC, W_MINC, W_MINC, W_MINC, W_MINC,
                        W_MINC, W_MINC, W_MINC, W_MINC, 1'b1));
    send_site(make_site(W_MAXC, W_MAXC, W_MAXC, W_MAXC, W_MAXC, W_MAXC,
                        W_MAXC, W_MAXC, W_MAXC, W_MAXC, 1'b1));
    send_site(make_site(W_ONE, W_ZERO, W_ZERO, W_ZERO, W_ONE, W_ZERO,
                        W_ZERO, W_ZERO, W_ONE, W_ONE, 1'b1));
    send_site(make_site(W_ONE, W_ZERO, W_ZERO, W_ZERO, W_ONE, W_ZERO,
                        W_ZERO, W_ZERO, W_ONE, W_J, 1'b1));
    send_site(make_site(W_NEG, W_ZERO, W_ZERO, W_ZERO, W_NEG, W_ZERO,
                        W_ZERO, W_ZERO, W_NEG, W_NEG, 1'b1));
    send_site(det_site(W_MAXC, 1'b1));
    send_site(det_site(W_CONJ, 1'b1));
    send_site(det_site(W_MINC, 1'b1));
    send_site(make_site(32'h0001_0000, 32'h0000_0001, 32'hFFFF_0000, 32'h0000_FFFF,
                        32'h0001_0001, W_ZERO, W_TINY, 32'h0001_0000, 32'h0000_0001,
                        32'h0001_FFFF, 1'b1));
    send_site(det_site(W_MAXC, 1'b0));
    send_site(make_site(W_ONE, W_ZERO, W_ZERO, W_ZERO, W_ONE, W_ZERO,
                        W_ZERO, W_ZERO, W_ONE, W_J, 1'b0));
    send_site(random_site(1'b0));
    send_site(random_site(1'b1));
    send_site(det_site(W_ZERO, 1'b0));
    send_site(make_site(W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
                        W_ZERO, W_ZERO, W_ZERO, W_ZERO, 1'b1));
    wait_drained();
  endtask

  // grow real with large singlets, swing imag negative, then pull real back
  task automatic test_large_sums();
    repeat (16) send_site(det_site(W_MAXC, 1'b0));
    repeat (12) send_site(det_site(W_CONJ, 1'b0));
    repeat (6) send_site(det_site(W_MINC, 1'b0));
    send_site(det_site(W_MINC, 1'b1));
    wait_drained();
  endtask

  // hold the output off long enough that the input stalls behind it
  task automatic test_backpressure();
    calm    = 1'b1;
    rx_hold = 400;
    repeat (30) send_site(random_site(1'b1));
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sums();
    int done;
    int len;
    done = 0;
    while (done < 570) begin
      calm = (done >= 200 && done < 320);
      if ($urandom_range(99) < 5) wait_drained();
      case ($urandom_range(9))
        0:          len = $urandom_range(17, 40);
        1, 2, 3:    len = $urandom_range(5, 16);
        default:    len = $urandom_range(1, 4);
      endcase
      for (int k = 0; k < len; k++) begin
        send_site(random_site(k == len - 1));
        done++;
      end
    end
    calm = 1'b0;
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      result_ready = 1'b0;
      rx_hold      = rx_hold - 1;
    end else begin
      result_ready = calm || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_sums.size() == 0) begin
        report_error("result word with no sum pending");
      end else begin
        want = pending_sums.pop_front();
        if (result.sum_real !== want.sum_real)
          report_error($sformatf("sum %0d real: got %0d want %0d",
                                 sums_checked, result.sum_real, want.sum_real));
        if (result.sum_imag !== want.sum_imag)
          report_error($sformatf("sum %0d imag: got %0d want %0d",
                                 sums_checked, result.sum_imag, want.sum_imag));
        if (result.saturated !== want.saturated)
          report_error($sformatf("sum %0d saturated: got %b want %b",
                                 sums_checked, result.saturated, want.saturated));
        sums_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d with %0d sums outstanding", cycles, pending_sums.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    acc_real_m  = 0;
    acc_imag_m  = 0;
    clip_seen_m = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_large_sums();
    test_backpressure();
    test_random_sums();
    repeat (30) @(negedge clk);
    if (pending_sums.size() != 0)
      report_error($sformatf("%0d sums never arrived", pending_sums.size()));
    $display("Covered %0d sites, %0d sums checked: edge operands, long large-valued sums,",
             sites_sent, sums_checked);
    $display("a long output stall backing up the input, and random sums of mixed length.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bsma_pkg.sv
hdl/baryon_singlet_momentum_accumulate.sv
tb/sv/tb.sv
